// File: rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Types and codes shared by the shifting array list and its storage cells.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int OPCODE_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PREPEND    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_FIND       = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_ALL = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      found;
        logic [POS_W-1:0]          found_position;
        logic [COUNT_W-1:0]        removed_count;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
        logic [STATUS_W-1:0]       status;
    } rsp_t;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CK_HOLD,
        CK_LOAD,
        CK_INSERT,
        CK_DELETE,
        CK_ROTATE
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t kind;
        logic       keep;
    } cell_cmd_t;

endpackage

// File: rtl/sal_cell.sv
// ----------------------------------------------------------------------------
// sal_cell
// One entry of the list. Holds, loads, or takes a neighbor's word or the head's word as the
// broadcast command and its own place in the row decide.
// ----------------------------------------------------------------------------
module sal_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  sal_pkg::cell_cmd_t    cmd_i,
    input  logic [IDX_W-1:0]      at_i,
    input  logic [DATA_WIDTH-1:0] val_i,
    input  logic [DATA_WIDTH-1:0] left_i,
    input  logic [DATA_WIDTH-1:0] right_i,
    input  logic [DATA_WIDTH-1:0] head_i,
    output logic [DATA_WIDTH-1:0] q_o
);
    import sal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (cmd_i.kind)
            CK_HOLD: begin
                data_next = data_reg;
            end
            CK_LOAD: begin
                if (MY_IDX == at_i) data_next = val_i;
            end
            CK_INSERT: begin
                if (MY_IDX > at_i) data_next = left_i;
                else if (MY_IDX == at_i) data_next = val_i;
            end
            CK_DELETE: begin
                if (MY_IDX >= at_i) data_next = right_i;
            end
            CK_ROTATE: begin
                // the ring tail takes the word leaving the head
                if (MY_IDX < at_i) data_next = right_i;
                else if (MY_IDX == at_i) data_next = cmd_i.keep ? head_i : right_i;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q_o = data_reg;

endmodule

// File: rtl/shifting_array_list.sv
// ----------------------------------------------------------------------------
// shifting_array_list
// Packed list of signed words held in a row of cells: push, pop, read,
// insert, prepend, delete, find and remove-all requests, one result each.
// ----------------------------------------------------------------------------
//  channel   ports                    moves
//  request   s_valid s_ready s_req    opcode, item_value, position
//  result    m_valid m_ready m_rsp    value, found, counts, status
//
//  push, prepend, insert, delete and every failed request finish without a scan.
//  otherwise pop, read, find and remove all rotate the cell ring once, one step
//  per held entry; find and remove all on an empty list finish without a
//  scan. One request is in work at a time.
//  reset clears the state, the count and the result valid flag; entry storage needs no clearing pass.
//  a result waits in the output register; the next request is taken as it
//  leaves.
// ----------------------------------------------------------------------------
module shifting_array_list #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sal_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output sal_pkg::rsp_t m_rsp
);
    import sal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    rsp_t                         m_rsp_reg, m_rsp_next;

    logic [OPCODE_W-1:0]          op_reg, op_next;
    logic [DATA_WIDTH-1:0]        val_reg, val_next;
    logic [CW-1:0]                len_reg, len_next;
    logic [CW-1:0]                step_reg, step_next;
    logic [CW-1:0]                tgt_reg, tgt_next;
    logic                         found_reg, found_next;
    logic [CW-1:0]                fpos_reg, fpos_next;
    logic signed [DATA_WIDTH-1:0] rd_reg, rd_next;

    logic [DATA_WIDTH-1:0]        cells_q [DEPTH];
    cell_cmd_t                    cell_cmd;
    logic [IW-1:0]                cell_at;
    logic [DATA_WIDTH-1:0]        in_val;
    logic [DATA_WIDTH-1:0]        head;

    logic                         accept;
    logic                         done;
    logic [STATUS_W-1:0]          status;
    logic [IW-1:0]                pos_ext;
    logic                         pos_oor;
    logic                         is_full;
    logic                         is_zero;
    logic                         hit;
    logic                         last_step;
    logic                         rm_op;

    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign in_val    = DATA_WIDTH'(s_req.item_value);
    assign pos_ext   = IW'(s_req.position);
    assign pos_oor   = pos_ext >= IW'(cnt_reg);
    assign is_full   = cnt_reg == CW'(DEPTH);
    assign is_zero   = cnt_reg == '0;
    assign head      = cells_q[0];
    assign hit       = head == val_reg;
    assign last_step = step_reg == (cnt_reg - CW'(1));
    assign rm_op     = op_reg == OP_REMOVE_ALL;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        len_next     = len_reg;
        step_next    = step_reg;
        tgt_next     = tgt_reg;
        found_next   = found_reg;
        fpos_next    = fpos_reg;
        rd_next      = rd_reg;
        cell_cmd     = '{kind: CK_HOLD, keep: 1'b0};
        cell_at      = '0;
        done         = 1'b0;
        status       = ST_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    done       = 1'b1;
                    op_next    = s_req.opcode;
                    val_next   = in_val;
                    len_next   = cnt_reg;
                    step_next  = '0;
                    tgt_next   = '0;
                    found_next = 1'b0;
                    fpos_next  = '0;
                    rd_next    = '0;
                    unique case (s_req.opcode) inside
                        OP_PUSH: begin
                            if (is_full) begin
                                status = ST_FULL;
                            end else begin
                                cell_cmd.kind = CK_LOAD;
                                cell_at       = IW'(cnt_reg);
                                cnt_next      = cnt_reg + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (is_zero) begin
                                status = ST_EMPTY;
                            end else begin
                                done       = 1'b0;
                                tgt_next   = cnt_reg - CW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (pos_oor) begin
                                status = ST_RANGE;
                            end else begin
                                done       = 1'b0;
                                tgt_next   = CW'(s_req.position);
                                state_next = S_SCAN;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_oor) begin
                                status = ST_RANGE;
                            end else if (is_full) begin
                                status = ST_FULL;
                            end else begin
                                cell_cmd.kind = CK_INSERT;
                                cell_at       = pos_ext;
                                cnt_next      = cnt_reg + CW'(1);
                            end
                        end
                        OP_PREPEND: begin
                            if (is_full) begin
                                status = ST_FULL;
                            end else begin
                                cell_cmd.kind = CK_INSERT;
                                cell_at       = '0;
                                cnt_next      = cnt_reg + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (pos_oor) begin
                                status = ST_RANGE;
                            end else begin
                                cell_cmd.kind = CK_DELETE;
                                cell_at       = pos_ext;
                                cnt_next      = cnt_reg - CW'(1);
                            end
                        end
                        OP_FIND, OP_REMOVE_ALL: begin
                            if (!is_zero) begin
                                done       = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one ring step: head leaves, survivors go to the tail
                cell_cmd.kind = CK_ROTATE;
                cell_cmd.keep = !(rm_op && hit);
                cell_at       = IW'(len_reg - CW'(1));
                if (rm_op && hit) len_next = len_reg - CW'(1);
                if ((op_reg == OP_POP || op_reg == OP_READ) && step_reg == tgt_reg) begin
                    rd_next = head;
                end
                if (op_reg == OP_FIND && hit && !found_reg) begin
                    found_next = 1'b1;
                    fpos_next  = step_reg;
                end
                step_next = step_reg + CW'(1);
                if (last_step) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_POP) cnt_next = cnt_reg - CW'(1);
                    if (rm_op) cnt_next = len_next;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (done) begin
            m_valid_next              = 1'b1;
            m_rsp_next.read_value     = VALUE_W'(rd_next);
            m_rsp_next.found          = found_next;
            m_rsp_next.found_position = POS_W'(fpos_next);
            m_rsp_next.removed_count  = '0;
            m_rsp_next.entry_count    = COUNT_W'(cnt_next);
            m_rsp_next.is_empty       = cnt_next == '0;
            m_rsp_next.status         = status;
            if (state_reg == S_SCAN && rm_op) begin
                m_rsp_next.removed_count = COUNT_W'(cnt_reg - len_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        len_reg   <= len_next;
        step_reg  <= step_next;
        tgt_reg   <= tgt_next;
        found_reg <= found_next;
        fpos_reg  <= fpos_next;
        rd_reg    <= rd_next;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = in_val;
        end else begin : g_mid_l
            assign left_w = cells_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = cells_q[g];
        end else begin : g_mid_r
            assign right_w = cells_q[g+1];
        end

        sal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IW),
            .IDX        (g)
        ) u_cell (
            .aclk    (aclk),
            .cmd_i   (cell_cmd),
            .at_i    (cell_at),
            .val_i   (in_val),
            .left_i  (left_w),
            .right_i (right_w),
            .head_i  (head),
            .q_o     (cells_q[g])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (step_reg < cnt_reg && len_reg <= cnt_reg))
        else $error("ring scan out of bounds");

    a_scan_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !m_valid_reg)
        else $error("result pending while a scan runs");

    a_count_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && state_reg == S_IDLE) |-> (m_rsp_reg.entry_count == COUNT_W'(cnt_reg)))
        else $error("reported entry count differs from held count");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && last_step) |=> (state_reg == S_IDLE && m_valid_reg))
        else $error("scan end without result");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shifting array list. Requests come from a queue
// filled at time zero: a directed opening, then phases that fill the list to
// capacity, drain it and mix every opcode. Each accepted request is run
// through a list image kept in the bench and every result is compared field
// by field, with random stalls on both channels and one long result back-up.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sal_pkg::*;

    localparam int DEPTH          = 64;
    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 600;
    localparam int TAIL_ITEMS     = 60;
    localparam int LONG_HOLD_AT   = 150;
    localparam int LONG_HOLD_CYC  = 250;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [DEPTH-1:0][VALUE_W-1:0] cells;
        logic [COUNT_W-1:0]            fill;
    } list_image_t;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_req   = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_rsp;

    req_t        request_queue [$];
    rsp_t        awaited_results [$];
    list_image_t plan_list;
    list_image_t live_list;
    bit          plan_done;
    bit          req_taken;
    int          planned_count;
    int          reqs_accepted;
    int          results_checked;
    int          fail_count;
    int          peak_fill;
    int          finds_hit;
    int          entries_removed;
    int          status_seen [4];

    int send_gap;
    int send_run;
    int stall_left;
    int ready_run;
    int hold_left;
    bit long_hold_done;

    shifting_array_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // applies one request to a list image and forms its result
    task automatic apply_request(inout list_image_t img, input req_t rq, output rsp_t rs);
        logic [POS_W-1:0] at;
        int               i;
        int               w;
        rs = '0;
        at = rq.position;
        case (rq.opcode) inside
            OP_PUSH: begin
                if (img.fill >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    img.cells[img.fill] = rq.item_value;
                    img.fill = img.fill + COUNT_W'(1);
                end
            end
            OP_POP: begin
                if (img.fill == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    img.fill = img.fill - COUNT_W'(1);
                    rs.read_value = img.cells[img.fill];
                end
            end
            OP_READ: begin
                if (at >= img.fill) rs.status = ST_RANGE;
                else rs.read_value = img.cells[at];
            end
            OP_INSERT, OP_PREPEND: begin
                if (rq.opcode == OP_PREPEND) at = '0;
                // range check wins over the full check
                if (rq.opcode == OP_INSERT && at >= img.fill) begin
                    rs.status = ST_RANGE;
                end else if (img.fill >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    for (i = img.fill; i > at; i = i - 1) img.cells[i] = img.cells[i-1];
                    img.cells[at] = rq.item_value;
                    img.fill = img.fill + COUNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (at >= img.fill) begin
                    rs.status = ST_RANGE;
                end else begin
                    for (i = at; i + 1 < img.fill; i = i + 1) img.cells[i] = img.cells[i+1];
                    img.fill = img.fill - COUNT_W'(1);
                end
            end
            OP_FIND: begin
                for (i = 0; i < img.fill; i = i + 1) begin
                    if (!rs.found && img.cells[i] == rq.item_value) begin
                        rs.found          = 1'b1;
                        rs.found_position = POS_W'(i);
                    end
                end
            end
            OP_REMOVE_ALL: begin
                w = 0;
                for (i = 0; i < img.fill; i = i + 1) begin
                    if (img.cells[i] != rq.item_value) begin
                        img.cells[w] = img.cells[i];
                        w = w + 1;
                    end
                end
                rs.removed_count = COUNT_W'(img.fill - w);
                img.fill = COUNT_W'(w);
            end
        endcase
        rs.entry_count = img.fill;
        rs.is_empty    = (img.fill == 0);
    endtask

    task automatic plan_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] at);
        req_t rq;
        rsp_t plan_rsp;
        rq.opcode     = op;
        rq.item_value = value;
        rq.position   = at;
        apply_request(plan_list, rq, plan_rsp);
        request_queue.push_back(rq);
        planned_count++;
    endtask

    // values lean toward ones already held so finds and removals hit
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(9, 0);
        if (sel < 4) return $urandom;
        if (sel < 7 && plan_list.fill != 0) return plan_list.cells[$urandom_range(plan_list.fill - 1, 0)];
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            default: return $urandom_range(3, 1);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if (plan_list.fill != 0 && $urandom_range(3, 0) != 0)
            return POS_W'($urandom_range(plan_list.fill - 1, 0));
        return POS_W'($urandom_range(63, 0));
    endfunction

    function automatic bit in_tail();
        return plan_done && request_queue.size() < TAIL_ITEMS;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // monitor: predicts on each accepted request, checks each accepted result
    always @(posedge aclk) begin
        rsp_t want;
        req_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_request(live_list, s_req, want);
                awaited_results.push_back(want);
                req_taken = 1'b1;
                reqs_accepted++;
                if (live_list.fill > peak_fill) peak_fill = live_list.fill;
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with no request waiting, got %h", $time, m_rsp);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("read_value", want.read_value, m_rsp.read_value);
                    check_field("found", want.found, m_rsp.found);
                    check_field("found_position", want.found_position, m_rsp.found_position);
                    check_field("removed_count", want.removed_count, m_rsp.removed_count);
                    check_field("entry_count", want.entry_count, m_rsp.entry_count);
                    check_field("is_empty", want.is_empty, m_rsp.is_empty);
                    check_field("status", want.status, m_rsp.status);
                    results_checked++;
                    status_seen[want.status]++;
                    if (want.found) finds_hit++;
                    entries_removed += want.removed_count;
                end
            end
        end
    end

    // driver: offers requests, valid held until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                s_valid <= 1'b1;
                s_req   <= request_queue.pop_front();
                if (send_run > 0) begin
                    send_run--;
                end else if (!in_tail()) begin
                    send_gap = $urandom_range(18, 1);
                    send_run = $urandom_range(40, 0);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls plus one long back-up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && reqs_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYC - 1;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (ready_run != 0) begin
                ready_run--;
            end else if (!in_tail()) begin
                stall_left = $urandom_range(18, 1);
                ready_run  = $urandom_range(60, 0);
            end
        end
    end

    initial begin
        int                  phase_no;
        int                  sel;
        logic [OPCODE_W-1:0] op;
        plan_list = '0;
        live_list = '0;
        send_run  = $urandom_range(20, 0);
        ready_run = $urandom_range(20, 0);

        // directed opening on an empty list, then a short list
        plan_request(OP_POP,        '0,           6'd0);
        plan_request(OP_READ,       '0,           6'd0);
        plan_request(OP_DELETE,     '0,           6'd0);
        plan_request(OP_INSERT,     32'd9,        6'd0);
        plan_request(OP_FIND,       '0,           6'd0);
        plan_request(OP_REMOVE_ALL, '0,           6'd0);
        plan_request(OP_PREPEND,    32'h8000_0000, 6'd0);
        plan_request(OP_PUSH,       32'h7fff_ffff, 6'd0);
        plan_request(OP_PUSH,       '1,           6'd0);
        plan_request(OP_PREPEND,    '0,           6'd63);
        plan_request(OP_INSERT,     '1,           6'd2);
        plan_request(OP_READ,       '0,           6'd63);
        plan_request(OP_READ,       '0,           6'd4);
        plan_request(OP_FIND,       '1,           6'd0);
        plan_request(OP_FIND,       32'd12345,    6'd0);
        plan_request(OP_REMOVE_ALL, '1,           6'd0);
        plan_request(OP_INSERT,     32'd5,        6'd2);
        plan_request(OP_DELETE,     '0,           6'd3);
        plan_request(OP_DELETE,     '0,           6'd0);
        plan_request(OP_READ,       '0,           6'd0);
        plan_request(OP_POP,        '0,           6'd0);
        plan_request(OP_POP,        '0,           6'd0);

        // random phases: fill to capacity, drain to empty, or a mix
        phase_no = 0;
        while (planned_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            sel = (phase_no < 2) ? phase_no : $urandom_range(3, 0);
            phase_no++;
            if (sel == 0) begin
                while (plan_list.fill < DEPTH) begin
                    case ($urandom_range(2, 0))
                        0:       op = OP_PUSH;
                        1:       op = OP_PREPEND;
                        default: op = OP_INSERT;
                    endcase
                    plan_request(op, pick_value(), pick_pos());
                end
                // requests against a full list
                plan_request(OP_PUSH, pick_value(), pick_pos());
                plan_request(OP_PREPEND, pick_value(), pick_pos());
                plan_request(OP_INSERT, pick_value(), POS_W'($urandom_range(63, 0)));
                plan_request(OP_FIND, pick_value(), pick_pos());
                plan_request(OP_READ, '0, 6'd63);
            end else if (sel == 1) begin
                while (plan_list.fill != 0) begin
                    op = $urandom_range(1, 0) ? OP_POP : OP_DELETE;
                    plan_request(op, pick_value(), pick_pos());
                end
                plan_request(OP_POP, pick_value(), pick_pos());
                plan_request(OP_DELETE, pick_value(), pick_pos());
                plan_request(OP_READ, pick_value(), pick_pos());
            end else begin
                repeat ($urandom_range(60, 20)) begin
                    op = OPCODE_W'($urandom_range(7, 0));
                    plan_request(op, pick_value(), pick_pos());
                end
            end
        end
        plan_done = 1'b1;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_valid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d checked results, peak fill %0d of %0d",
                 reqs_accepted, results_checked, peak_fill, DEPTH);
        $display("status ok %0d, full %0d, empty %0d, out of range %0d; finds hit %0d, removed %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_RANGE], finds_hit, entries_removed);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results still awaited", awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/sal_pkg.sv
rtl/sal_cell.sv
rtl/shifting_array_list.sv
sim/tb_top.sv
